// ----- sv/imusi_pkg.sv -----
// Shared types and constants of the IMU static start-up statistics block.
package imusi_pkg;

   // Divider geometry
   localparam int DIV_NUM_W = 64;
   localparam int DIV_DEN_W = 32;
   localparam int DIV_CNT_W = 7;

   // Fixed-point constants
   localparam int ONE_Q16 = 65536;
   localparam logic [31:0] VAR_RESET = 32'd6554;

   // Register reset values
   localparam logic [15:0] INIT_MAX_RESET = 16'd20;
   localparam logic [30:0] GRAV_RESET     = 31'd642908;
   localparam logic [30:0] ACC_VAR_RESET  = 31'd6554;
   localparam logic [30:0] GYRO_VAR_RESET = 31'd6554;

   // Register indexes
   localparam logic [1:0] REG_INIT_MAX = 2'd0;
   localparam logic [1:0] REG_GRAV     = 2'd1;
   localparam logic [1:0] REG_ACC_VAR  = 2'd2;
   localparam logic [1:0] REG_GYRO_VAR = 2'd3;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
      logic [DIV_CNT_W-1:0] bits;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quo;
   } div_rsp_type;

endpackage

// ----- sv/imu_static_init_statistics.sv -----
// Top level: running mean/variance per IMU channel and gravity report.
// Each sample takes four divisions per channel, all on one shared radix-2 divider.
// A frame end adds nine transactions, receiver ready. Samples are taken one at a time,
// each after the last sample and any report after its frame end are done.
// Reset: synchronous, active high; unwritten channels read as the reset mean and variance.
module imu_static_init_statistics
   import imusi_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 32,
   parameter int COUNT_WIDTH  = 16,
   localparam int REQ_W = ((6 * SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z from the lowest bit up
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             req_tlast,
   input  logic             req_tvalid,
   output logic             req_tready,
   // channel[3:0], mean_value[35:4], variance_value[67:36]
   output logic [71:0]      rsp_tdata,
   // initialized
   output logic             rsp_tuser,
   output logic             rsp_tlast,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic             csr_wen,
   input  logic [1:0]       csr_index,
   input  logic [30:0]      csr_wdata
);

   localparam int S   = SAMPLE_WIDTH;
   localparam int C   = COUNT_WIDTH;
   localparam int MW  = (S > 18) ? S : 18;
   localparam int MWX = MW + 1;
   localparam int NB_MEAN = ((MWX > C - 1) ? MWX : C - 1) + 1;
   localparam int RAM_W = MW + 32;
   localparam logic signed [MW-1:0] MEAN_NEG_ONE = -(MW'(ONE_Q16));
   localparam logic [C-1:0] CMAX = {C{1'b1}};

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_RD    = 5'd1;
   localparam logic [4:0] ST_RDW   = 5'd2;
   localparam logic [4:0] ST_DMEAN = 5'd3;
   localparam logic [4:0] ST_WMEAN = 5'd4;
   localparam logic [4:0] ST_MAG   = 5'd5;
   localparam logic [4:0] ST_MUL   = 5'd6;
   localparam logic [4:0] ST_DS    = 5'd7;
   localparam logic [4:0] ST_WS    = 5'd8;
   localparam logic [4:0] ST_WT    = 5'd9;
   localparam logic [4:0] ST_WV    = 5'd10;
   localparam logic [4:0] ST_CNT   = 5'd11;
   localparam logic [4:0] ST_ORD   = 5'd12;
   localparam logic [4:0] ST_ORDW  = 5'd13;
   localparam logic [4:0] ST_OUT   = 5'd14;
   localparam logic [4:0] ST_GABS  = 5'd15;
   localparam logic [4:0] ST_SHIFT = 5'd16;
   localparam logic [4:0] ST_SQ    = 5'd17;
   localparam logic [4:0] ST_SQADD = 5'd18;
   localparam logic [4:0] ST_SQRT  = 5'd19;
   localparam logic [4:0] ST_GMUL  = 5'd20;
   localparam logic [4:0] ST_GDIV  = 5'd21;
   localparam logic [4:0] ST_GWAIT = 5'd22;
   localparam logic [4:0] ST_GOUT  = 5'd23;

   // Control and configuration
   logic [4:0]  state_ff, state_in;
   logic [2:0]  k_ff, k_in;
   logic [5:0]  valid_ff, valid_in;
   logic [C-1:0] count_ff, count_in;
   logic        init_ff, init_in;
   logic [15:0] lim_ff, lim_in;
   logic [30:0] grav_ff, grav_in;
   logic [30:0] accv_ff, accv_in;
   logic [30:0] gyrv_ff, gyrv_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // Datapath
   logic [6*S-1:0]         smp_ff, smp_in;
   logic                   fe_ff, fe_in;
   logic signed [MW-1:0]   m_ff, m_in;
   logic [31:0]            v_ff, v_in;
   logic signed [MWX-1:0]  diff_ff, diff_in;
   logic signed [MW-1:0]   mnew_ff, mnew_in;
   logic [31:0]            mag_ff, mag_in;
   logic [63:0]            sq_ff, sq_in;
   logic [47:0]            s_ff, s_in;
   logic [47:0]            term_ff, term_in;
   logic signed [MW-1:0]   macc_ff [3];
   logic signed [MW-1:0]   macc_in [3];
   logic [63:0]            a_ff [3];
   logic [63:0]            a_in [3];
   logic [63:0]            sum_ff, sum_in;
   logic [63:0]            prod_ff, prod_in;
   logic [63:0]            rv_ff, rv_in;
   logic [63:0]            r_ff, r_in;
   logic [63:0]            bit_ff, bit_in;
   logic [31:0]            g_ff, g_in;
   logic [3:0]             ochan_ff, ochan_in;
   logic [31:0]            omean_ff, omean_in;
   logic [31:0]            ovar_ff, ovar_in;
   logic                   oinit_ff, oinit_in;
   logic                   olast_ff, olast_in;

   // Memory and divider
   logic               ram_wen;
   logic [2:0]         ram_addr;
   logic [RAM_W-1:0]   ram_wdata;
   logic [RAM_W-1:0]   ram_rdata;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   // Combinational helpers
   logic signed [S-1:0]   x_raw;
   logic signed [MWX-1:0] x_ext;
   logic signed [MW-1:0]  rd_mean;
   logic [31:0]           rd_var;
   logic [MWX-1:0]        dabs;
   logic [MWX-1:0]        qm;
   logic signed [MWX-1:0] mnew_w;
   logic signed [MWX-1:0] e_w;
   logic [MWX-1:0]        eabs;
   logic [63:0]           e64;
   logic [31:0]           vv;
   logic [48:0]           tot;
   logic [31:0]           var_new;
   logic [C-1:0]          cnt_next;
   logic [1:0]            k2;
   logic [31:0]           norm;
   logic [63:0]           rb;
   logic [63:0]           gq;
   logic                   big;
   logic [MW-1:0]          mabs [3];
   logic signed [63:0]     m64;
   logic [31:0]            msat;

   assign k2    = k_ff[1:0];
   assign x_raw = smp_ff[k_ff * S +: S];
   assign x_ext = MWX'(x_raw);
   assign norm  = r_ff[31:0];
   assign rb    = r_ff + bit_ff;

   imusi_ram #(
      .WIDTH (RAM_W),
      .DEPTH (6)
   ) u_ram (
      .clock (clock),
      .wen   (ram_wen),
      .waddr (ram_addr),
      .wdata (ram_wdata),
      .raddr (ram_addr),
      .rdata (ram_rdata)
   );

   imusi_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Stored entry or its reset value
   always_comb begin
      if (valid_ff[k_ff]) begin
         rd_mean = ram_rdata[RAM_W-1:32];
         rd_var  = ram_rdata[31:0];
      end else begin
         rd_mean = (k_ff == 3'd2) ? MEAN_NEG_ONE : '0;
         rd_var  = VAR_RESET;
      end
   end

   // Magnitudes and saturation
   always_comb begin
      dabs   = diff_ff[MWX-1] ? (~diff_ff + 1'b1) : diff_ff;
      qm     = div_rsp.quo[MWX-1:0];
      mnew_w = diff_ff[MWX-1] ? (MWX'(m_ff) - signed'(qm)) : (MWX'(m_ff) + signed'(qm));
      e_w    = x_ext - MWX'(mnew_ff);
      eabs   = e_w[MWX-1] ? (~e_w + 1'b1) : e_w;
      e64    = 64'(eabs);
      vv     = v_ff - div_rsp.quo[31:0];
      tot    = 49'(vv) + 49'(term_ff);
      var_new = (tot[48:32] != '0) ? 32'hFFFF_FFFF : tot[31:0];
      cnt_next = (count_ff < CMAX) ? (count_ff + 1'b1) : count_ff;
      for (int i = 0; i < 3; i++) begin
         mabs[i] = macc_ff[i][MW-1] ? (~macc_ff[i] + 1'b1) : macc_ff[i];
      end
      big = ((a_ff[0] >> 31) != '0) || ((a_ff[1] >> 31) != '0) || ((a_ff[2] >> 31) != '0);
      gq  = div_rsp.quo;
      m64 = 64'(m_ff);
      if (m64 > 64'sd2147483647) begin
         msat = 32'h7FFF_FFFF;
      end else if (m64 < -64'sd2147483648) begin
         msat = 32'h8000_0000;
      end else begin
         msat = m64[31:0];
      end
   end

   // Sequencer and next state
   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      valid_in  = valid_ff;
      count_in  = count_ff;
      init_in   = init_ff;
      lim_in    = lim_ff;
      grav_in   = grav_ff;
      accv_in   = accv_ff;
      gyrv_in   = gyrv_ff;
      smp_in    = smp_ff;
      fe_in     = fe_ff;
      m_in      = m_ff;
      v_in      = v_ff;
      diff_in   = diff_ff;
      mnew_in   = mnew_ff;
      mag_in    = mag_ff;
      sq_in     = sq_ff;
      s_in      = s_ff;
      term_in   = term_ff;
      macc_in   = macc_ff;
      a_in      = a_ff;
      sum_in    = sum_ff;
      prod_in   = prod_ff;
      rv_in     = rv_ff;
      r_in      = r_ff;
      bit_in    = bit_ff;
      g_in      = g_ff;
      ochan_in  = ochan_ff;
      omean_in  = omean_ff;
      ovar_in   = ovar_ff;
      oinit_in  = oinit_ff;
      olast_in  = olast_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;

      ram_wen   = 1'b0;
      ram_addr  = k_ff;
      ram_wdata = {mnew_ff, var_new};

      div_req.start = 1'b0;
      div_req.num   = '0;
      div_req.den   = DIV_DEN_W'(count_ff);
      div_req.bits  = DIV_CNT_W'(NB_MEAN);

      // Configuration writes
      if (csr_wen) begin
         case (csr_index)
            REG_INIT_MAX: lim_in  = csr_wdata[15:0];
            REG_GRAV:     grav_in = csr_wdata;
            REG_ACC_VAR:  accv_in = csr_wdata;
            REG_GYRO_VAR: gyrv_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            // Take a sample; drop it once initialized
            if (req_tvalid && !init_ff) begin
               smp_in   = req_tdata[6*S-1:0];
               fe_in    = req_tlast;
               k_in     = 3'd0;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_RDW;
         end
         ST_RDW: begin
            m_in     = rd_mean;
            v_in     = rd_var;
            diff_in  = x_ext - MWX'(rd_mean);
            state_in = ST_DMEAN;
         end
         ST_DMEAN: begin
            // Rounded mean step: (|x - m| + n/2) / n
            div_req.start = 1'b1;
            div_req.num   = 64'(dabs) + 64'(count_ff >> 1);
            state_in      = ST_WMEAN;
         end
         ST_WMEAN: begin
            if (div_rsp.done) begin
               mnew_in  = mnew_w[MW-1:0];
               state_in = ST_MAG;
            end
         end
         ST_MAG: begin
            mag_in   = (e64[63:32] != '0) ? 32'hFFFF_FFFF : e64[31:0];
            state_in = ST_MUL;
         end
         ST_MUL: begin
            sq_in    = 64'(mag_ff) * 64'(mag_ff);
            state_in = ST_DS;
         end
         ST_DS: begin
            div_req.start = 1'b1;
            div_req.num   = 64'(sq_ff[63:16]);
            div_req.bits  = DIV_CNT_W'(48);
            state_in      = ST_WS;
         end
         ST_WS: begin
            // s = (e^2 >> 16) / n, then s / n
            if (div_rsp.done) begin
               s_in          = div_rsp.quo[47:0];
               div_req.start = 1'b1;
               div_req.num   = 64'(div_rsp.quo[47:0]);
               div_req.bits  = DIV_CNT_W'(48);
               state_in      = ST_WT;
            end
         end
         ST_WT: begin
            if (div_rsp.done) begin
               term_in       = s_ff - div_rsp.quo[47:0];
               div_req.start = 1'b1;
               div_req.num   = 64'(v_ff);
               div_req.bits  = DIV_CNT_W'(32);
               state_in      = ST_WV;
            end
         end
         ST_WV: begin
            // Write back mean and variance
            if (div_rsp.done) begin
               ram_wen = 1'b1;
               valid_in[k_ff] = 1'b1;
               if (k_ff < 3'd3) begin
                  macc_in[k2] = mnew_ff;
               end
               if (k_ff == 3'd5) begin
                  state_in = ST_CNT;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_RD;
               end
            end
         end
         ST_CNT: begin
            count_in = cnt_next;
            k_in     = 3'd0;
            if (!fe_ff) begin
               state_in = ST_IDLE;
            end else begin
               if (32'(cnt_next) > 32'(lim_ff)) begin
                  init_in = 1'b1;
               end
               state_in = ST_ORD;
            end
         end
         ST_ORD: begin
            state_in = ST_ORDW;
         end
         ST_ORDW: begin
            m_in     = rd_mean;
            v_in     = rd_var;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // Present one channel transaction
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               ochan_in     = 4'(k_ff);
               omean_in     = msat;
               if (init_ff) begin
                  ovar_in = (k_ff < 3'd3) ? 32'(accv_ff) : 32'(gyrv_ff);
               end else begin
                  ovar_in = v_ff;
               end
               oinit_in = init_ff;
               olast_in = 1'b0;
               if (k_ff == 3'd5) begin
                  state_in = ST_GABS;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_ORD;
               end
            end
         end
         ST_GABS: begin
            for (int i = 0; i < 3; i++) begin
               a_in[i] = 64'(mabs[i]);
            end
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            // Scale all three until each fits 31 bits
            if (big) begin
               for (int i = 0; i < 3; i++) begin
                  a_in[i] = a_ff[i] >> 1;
               end
            end else begin
               k_in     = 3'd0;
               sum_in   = '0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            prod_in  = 64'(a_ff[k2][30:0]) * 64'(a_ff[k2][30:0]);
            state_in = ST_SQADD;
         end
         ST_SQADD: begin
            sum_in = sum_ff + prod_ff;
            if (k_ff == 3'd2) begin
               rv_in    = sum_ff + prod_ff;
               r_in     = '0;
               bit_in   = 64'd1 << 62;
               state_in = ST_SQRT;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_SQ;
            end
         end
         ST_SQRT: begin
            // Digit-by-digit square root, two bits per step
            if (bit_ff != '0) begin
               if (rv_ff >= rb) begin
                  rv_in = rv_ff - rb;
                  r_in  = (r_ff >> 1) + bit_ff;
               end else begin
                  r_in  = r_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end else begin
               k_in     = 3'd0;
               state_in = ST_GMUL;
            end
         end
         ST_GMUL: begin
            prod_in  = 64'(a_ff[k2][30:0]) * 64'(grav_ff);
            state_in = ST_GDIV;
         end
         ST_GDIV: begin
            if (norm == '0) begin
               g_in     = '0;
               state_in = ST_GOUT;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = prod_ff + 64'(norm >> 1);
               div_req.den   = norm;
               div_req.bits  = DIV_CNT_W'(DIV_NUM_W);
               state_in      = ST_GWAIT;
            end
         end
         ST_GWAIT: begin
            // Gravity points against the mean acceleration
            if (div_rsp.done) begin
               if (macc_ff[k2][MW-1]) begin
                  g_in = (gq > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : gq[31:0];
               end else begin
                  g_in = (gq > 64'h8000_0000) ? 32'h8000_0000 : (~gq[31:0] + 1'b1);
               end
               state_in = ST_GOUT;
            end
         end
         ST_GOUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               ochan_in     = 4'(k_ff) + 4'd6;
               omean_in     = g_ff;
               ovar_in      = '0;
               oinit_in     = init_ff;
               olast_in     = (k_ff == 3'd2);
               if (k_ff == 3'd2) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_GMUL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= 3'd0;
         valid_ff     <= '0;
         count_ff     <= C'(1);
         init_ff      <= 1'b0;
         lim_ff       <= INIT_MAX_RESET;
         grav_ff      <= GRAV_RESET;
         accv_ff      <= ACC_VAR_RESET;
         gyrv_ff      <= GYRO_VAR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         init_ff      <= init_in;
         lim_ff       <= lim_in;
         grav_ff      <= grav_in;
         accv_ff      <= accv_in;
         gyrv_ff      <= gyrv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      smp_ff   <= smp_in;
      fe_ff    <= fe_in;
      m_ff     <= m_in;
      v_ff     <= v_in;
      diff_ff  <= diff_in;
      mnew_ff  <= mnew_in;
      mag_ff   <= mag_in;
      sq_ff    <= sq_in;
      s_ff     <= s_in;
      term_ff  <= term_in;
      macc_ff  <= macc_in;
      a_ff     <= a_in;
      sum_ff   <= sum_in;
      prod_ff  <= prod_in;
      rv_ff    <= rv_in;
      r_ff     <= r_in;
      bit_ff   <= bit_in;
      g_ff     <= g_in;
      ochan_ff <= ochan_in;
      omean_ff <= omean_in;
      ovar_ff  <= ovar_in;
      oinit_ff <= oinit_in;
      olast_ff <= olast_in;
   end

   // Ports
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, ovar_ff, omean_ff, ochan_ff};
   assign rsp_tuser  = oinit_ff;
   assign rsp_tlast  = olast_ff;

endmodule

// ----- sv/imusi_ram.sv -----
// Generic single-port-write, registered-read RAM.
module imusi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wen,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wen) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/imusi_div.sv -----
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
module imusi_div
   import imusi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [DIV_DEN_W:0]   rem_sh;
   logic                 ge;
   logic [DIV_DEN_W:0]   rem_sub;
   logic [DIV_CNT_W-1:0] lshift;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DIV_NUM_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      rem_sub = rem_sh - {1'b0, den_ff};
      lshift  = DIV_CNT_W'(DIV_NUM_W) - div_req.bits;

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (busy_ff) begin
         // Shift in one quotient bit
         quo_in = {quo_ff[DIV_NUM_W-2:0], ge};
         rem_in = ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.start) begin
         // Align the numerator's top bit with the shift-out position
         quo_in  = div_req.num << lshift;
         rem_in  = '0;
         den_in  = div_req.den;
         cnt_in  = div_req.bits;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the IMU static start-up statistics block.
`timescale 1ns / 100ps

module tb;
   import imusi_pkg::*;

   localparam int HOLD_CYCLES  = 4000;
   localparam int DRAIN_CYCLES = 1600;
   localparam int STALL_LIMIT  = 20000;
   localparam logic [63:0] CLAMP32 = 64'hFFFF_FFFF;

   typedef struct packed {
      logic [3:0]  channel;
      logic [31:0] mean_value;
      logic [31:0] variance_value;
      logic        initialized;
      logic        last;
   } stat_type;

   typedef struct packed {
      logic [5:0][31:0] axes;   // accel xyz, rate xyz from index 0 up
      logic             frame_end;
      logic             pinned;   // accel x mean and variance typed in below
      logic [31:0]      pin_mean;
      logic [31:0]      pin_var;
   } row_type;

   logic         clock;
   logic         reset;
   logic [191:0] req_tdata;
   logic         req_tlast;
   logic         req_tvalid;
   logic         req_tready;
   logic [71:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic         csr_wen;
   logic [1:0]   csr_index;
   logic [30:0]  csr_wdata;

   imu_static_init_statistics u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Mirror of the block's statistics and registers
   logic signed [63:0] mean_st[6];
   logic [63:0]        var_st[6];
   logic [15:0]        count_st;
   bit                 done_st;
   logic [15:0]        limit_cf;
   logic [30:0]        grav_cf;
   logic [30:0]        accv_cf;
   logic [30:0]        gyrov_cf;

   stat_type stats_q[$];
   row_type  dir_rows[$];
   int    fails;
   int    sent;
   int    got;
   bit    rsp_hold_done;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [63:0] magnitude(input logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   // Quotient rounded to nearest, ties away from zero
   function automatic logic signed [63:0] div_nearest(input logic signed [63:0] num,
                                                      input logic [63:0] den);
      logic [63:0] q;
      q = (magnitude(num) + den / 2) / den;
      return num < 0 ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = '0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   task automatic reset_stats();
      for (int k = 0; k < 6; k++) begin
         mean_st[k] = '0;
         var_st[k]  = 64'(VAR_RESET);
      end
      mean_st[2] = -64'sd65536;
      count_st   = 16'd1;
      done_st    = 1'b0;
      limit_cf   = INIT_MAX_RESET;
      grav_cf    = GRAV_RESET;
      accv_cf    = ACC_VAR_RESET;
      gyrov_cf   = GYRO_VAR_RESET;
   endtask

   // Update the running statistics and queue the report of a frame end
   task automatic accumulate_sample(input logic [5:0][31:0] axes, input logic frame_end);
      logic [63:0]        n;
      logic signed [63:0] x;
      logic signed [63:0] m;
      logic [63:0]        e;
      logic [63:0]        s;
      logic [63:0]        tot;
      logic [63:0]        a[3];
      logic [63:0]        norm;
      logic [63:0]        q;
      logic signed [63:0] g;
      stat_type           r;
      if (done_st) return;
      n = (count_st == 0) ? 64'd1 : {48'd0, count_st};
      for (int k = 0; k < 6; k++) begin
         x = {{32{axes[k][31]}}, axes[k]};
         m = mean_st[k] + div_nearest(x - mean_st[k], n);
         mean_st[k] = m;
         e = magnitude(x - m);
         if (e > CLAMP32) e = CLAMP32;
         s = ((e * e) >> 16) / n;
         tot = (var_st[k] - var_st[k] / n) + (s - s / n);
         var_st[k] = (tot > CLAMP32) ? CLAMP32 : tot;
      end
      if (count_st != 16'hFFFF) count_st++;
      if (!frame_end) return;
      if (count_st > limit_cf) begin
         done_st = 1'b1;
         for (int k = 0; k < 3; k++) begin
            var_st[k]     = 64'(accv_cf);
            var_st[k + 3] = 64'(gyrov_cf);
         end
      end
      for (int k = 0; k < 6; k++) begin
         r.channel        = 4'(k);
         r.mean_value     = sat32(mean_st[k]);
         r.variance_value = var_st[k][31:0];
         r.initialized    = done_st;
         r.last           = 1'b0;
         stats_q = {stats_q, r};
      end
      // Gravity: scale accel means down together, then normalize
      for (int k = 0; k < 3; k++) a[k] = magnitude(mean_st[k]);
      while (a[0] >= 64'h8000_0000 || a[1] >= 64'h8000_0000 || a[2] >= 64'h8000_0000) begin
         for (int k = 0; k < 3; k++) a[k] = a[k] >> 1;
      end
      norm = floor_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
      for (int k = 0; k < 3; k++) begin
         g = '0;
         if (norm != 0) begin
            q = (a[k] * 64'(grav_cf) + norm / 2) / norm;
            g = (mean_st[k] < 0) ? $signed(q) : -$signed(q);
         end
         r.channel        = 4'(6 + k);
         r.mean_value     = sat32(g);
         r.variance_value = '0;
         r.initialized    = done_st;
         r.last           = (k == 2);
         stats_q = {stats_q, r};
      end
   endtask

   task automatic add_row(input logic [31:0] ax, input logic [31:0] ay, input logic [31:0] az,
                          input logic [31:0] gx, input logic [31:0] gy, input logic [31:0] gz,
                          input logic fe, input logic pin = 1'b0,
                          input logic [31:0] pmean = '0, input logic [31:0] pvar = '0);
      row_type w;
      w.axes      = {gz, gy, gx, az, ay, ax};
      w.frame_end = fe;
      w.pinned    = pin;
      w.pin_mean  = pmean;
      w.pin_var   = pvar;
      dir_rows = {dir_rows, w};
   endtask

   // Offer one sample, hold it until accepted, then predict
   task automatic send_sample(input logic [5:0][31:0] axes, input logic fe,
                              input logic pin = 1'b0, input logic [31:0] pmean = '0,
                              input logic [31:0] pvar = '0);
      int idx;
      bit free_run;
      free_run = (sent >= 30 && sent < 55);
      if (!free_run && $urandom_range(0, 99) < 9) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= axes;
      req_tlast  <= fe;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      idx = stats_q.size();
      accumulate_sample(axes, fe);
      // Typed-in value of the accel x report overrides the prediction
      if (pin && stats_q.size() > idx) begin
         stats_q[idx].mean_value     = pmean;
         stats_q[idx].variance_value = pvar;
      end
   endtask

   task automatic send_random(input bit force_end);
      logic [5:0][31:0] axes;
      logic             fe;
      if ($urandom_range(0, 99) < 80) begin
         // Standing platform: gravity on z, small noise everywhere
         axes[0] = $urandom_range(0, 4000) - 2000;
         axes[1] = $urandom_range(0, 4000) - 2000;
         axes[2] = -642908 + $urandom_range(0, 4000) - 2000;
         for (int k = 3; k < 6; k++) axes[k] = $urandom_range(0, 600) - 300;
      end else begin
         for (int k = 0; k < 6; k++) axes[k] = $urandom;
      end
      fe = force_end || ($urandom_range(0, 3) == 0);
      send_sample(axes, fe);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [30:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_INIT_MAX: limit_cf = val[15:0];
         REG_GRAV:     grav_cf  = val;
         REG_ACC_VAR:  accv_cf  = val;
         REG_GYRO_VAR: gyrov_cf = val;
         default: ;
      endcase
   endtask

   // Wait out all pending reports plus the work of a sample with no report
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (stats_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Receiver: accept reports, compare against the oldest expectation
   initial begin
      stat_type e;
      stat_type a;
      bit       free_run;
      rsp_tready    = 1'b0;
      got           = 0;
      rsp_hold_done = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            a.channel        = rsp_tdata[3:0];
            a.mean_value     = rsp_tdata[35:4];
            a.variance_value = rsp_tdata[67:36];
            a.initialized    = rsp_tuser;
            a.last           = rsp_tlast;
            got++;
            if (stats_q.size() == 0) begin
               $error("unexpected transaction: channel %0d", a.channel);
               fails++;
            end else begin
               e = stats_q.pop_front();
               if (a.channel != e.channel) begin
                  $error("channel: expected %0d, got %0d", e.channel, a.channel);
                  fails++;
               end
               if (a.mean_value != e.mean_value) begin
                  $error("mean_value: expected %h, got %h", e.mean_value, a.mean_value);
                  fails++;
               end
               if (a.variance_value != e.variance_value) begin
                  $error("variance_value: expected %h, got %h",
                         e.variance_value, a.variance_value);
                  fails++;
               end
               if (a.initialized != e.initialized) begin
                  $error("initialized: expected %0d, got %0d", e.initialized, a.initialized);
                  fails++;
               end
               if (a.last != e.last) begin
                  $error("last: expected %0d, got %0d", e.last, a.last);
                  fails++;
               end
            end
         end
         // Hold off once for a long stretch so the block backs up
         if (got == 30 && !rsp_hold_done) begin
            rsp_hold_done = 1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         free_run = (got >= 60 && got < 120);
         rsp_tready <= (free_run || $urandom_range(0, 99) >= 9);
      end
   end

   // Watchdog: end the run when nothing moves for too long
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Main sequence
   initial begin
      reset      = 1'b1;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      req_tvalid = 1'b0;
      csr_wen    = 1'b0;
      csr_index  = REG_INIT_MAX;
      csr_wdata  = '0;
      fails      = 0;
      sent       = 0;
      reset_stats();

      // Directed rows: extremes, zero accel, large errors, standing platform
      add_row(0, 0, 0, 0, 0, 0, 1, 1, 32'd0, 32'd0);
      add_row(0, 0, -642908, 0, 0, 0, 0);
      add_row(0, 0, -642908, 0, 0, 0, 1);
      add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
      add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 1);
      add_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
              32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 0);
      add_row(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
              32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1);
      add_row(-65536, 65536, 0, 1, -1, 0, 1);
      add_row(0, 0, 0, -1, -1, -1, 1);
      add_row(100, -100, -642900, 5, -5, 3, 0);
      add_row(-100, 100, -642916, -5, 5, -3, 0);
      add_row(50, 0, -642908, 0, 2, 0, 0);
      add_row(0, -50, -642908, 0, 0, -2, 1);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_sample(dir_rows[i].axes, dir_rows[i].frame_end, dir_rows[i].pinned,
                     dir_rows[i].pin_mean, dir_rows[i].pin_var);
      drain();

      // Never finish, gravity scale zero
      csr_write(REG_INIT_MAX, 31'd65535);
      csr_write(REG_GRAV, 31'd0);
      csr_write(REG_ACC_VAR, 31'h7FFF_FFFF);
      csr_write(REG_GYRO_VAR, 31'd0);
      csr_wen <= 1'b0;
      for (int i = 0; i < 40; i++) send_random(0);
      drain();

      // Limit one short of the count ceiling, full gravity scale
      csr_write(REG_INIT_MAX, 31'd65534);
      csr_write(REG_GRAV, 31'h7FFF_FFFF);
      csr_wen <= 1'b0;
      for (int i = 0; i < 40; i++) send_random(0);
      drain();

      // Limit zero: the next frame end finishes, later samples are dropped
      csr_write(REG_INIT_MAX, 31'd0);
      csr_write(REG_GRAV, GRAV_RESET);
      csr_write(REG_ACC_VAR, 31'd12345);
      csr_write(REG_GYRO_VAR, 31'h7FFF_FFFF);
      csr_wen <= 1'b0;
      for (int i = 0; i < 10; i++) send_random(i == 2);
      drain();

      if (fails == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
